[design/triangle_incircle_test_assert.svh]
// assertion macros for the incircle test block
// used by triangle_incircle_test; expects clk and arst_n in scope
`ifndef TRIANGLE_INCIRCLE_TEST_ASSERT_SVH
`define TRIANGLE_INCIRCLE_TEST_ASSERT_SVH

// same-cycle implication, off while in reset
`define TIC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication after a fixed number of cycles, off while in reset
`define TIC_ASSERT_DLY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

[design/tic_pkg.sv]
// shared types and constants for the incircle test block
// no dependencies; used by tic_det_sum and triangle_incircle_test
package tic_pkg;

	// cycles from an accepted transfer to its result strobe
	localparam int TIC_LATENCY = 10;

	// control that travels alongside the data in each of the later pipeline stages
	typedef struct packed {
		logic valid;
		logic swapped;
	} tic_ctl_t;

endpackage

[design/tic_det_sum.sv]
// back half of the incircle pipeline: lifted terms, split products, final sum and sign
// depends on tic_pkg (tic_ctl_t)
module tic_det_sum import tic_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tic_ctl_t                  ctl,
	input  logic [2*COORD_BITS:0]     sq [3],
	input  logic signed [2*COORD_BITS+1:0] mn [3],
	output tic_ctl_t                  res_ctl,
	output logic                      in_circle
);

	localparam int N   = COORD_BITS;
	localparam int L   = N + 1;          // split point of the wide operands
	localparam int SW  = 2 * N + 1;      // lifted term, unsigned
	localparam int MW  = 2 * N + 2;      // 2x2 minor, signed
	localparam int HSW = SW - L;         // upper part of lifted term
	localparam int HMW = MW - L;         // upper part of minor, signed
	localparam int LHW = L + 1 + HMW;    // low-by-high partial product
	localparam int HLW = HSW + L;        // high-by-low partial product
	localparam int HHW = HSW + 1 + HMW;  // high-by-high partial product
	localparam int MDW = 2 * N + 4;      // middle partial sum
	localparam int TW  = HHW + 2 * L;    // full product term
	localparam int DW  = TW + 1;         // determinant

	tic_ctl_t ctl_s6, ctl_s7, ctl_s8, ctl_s9, ctl_s10;

	logic        [2*L-1:0] ll_s6  [3];
	logic signed [LHW-1:0] lh_s6  [3];
	logic        [HLW-1:0] hl_s6  [3];
	logic signed [HHW-1:0] hh_s6  [3];
	logic signed [TW-1:0]  hi_s7  [3];
	logic signed [MDW-1:0] mid_s7 [3];
	logic signed [TW-1:0]  term_s8 [3];
	logic signed [DW-1:0]  pair_s9;
	logic signed [DW-1:0]  last_s9;
	logic signed [DW-1:0]  det_c;
	logic                  inside_s10;

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6  <= '0;
			ctl_s7  <= '0;
			ctl_s8  <= '0;
			ctl_s9  <= '0;
			ctl_s10 <= '0;
		end else begin
			ctl_s6  <= ctl;
			ctl_s7  <= ctl_s6;
			ctl_s8  <= ctl_s7;
			ctl_s9  <= ctl_s8;
			ctl_s10 <= ctl_s9;
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_term
		logic        [L-1:0]   s_lo;
		logic        [HSW-1:0] s_hi;
		logic        [L-1:0]   m_lo;
		logic signed [HMW-1:0] m_hi;

		assign s_lo = sq[g][L-1:0];
		assign s_hi = sq[g][SW-1:L];
		assign m_lo = mn[g][L-1:0];
		assign m_hi = $signed(mn[g][MW-1:L]);

		// four partial products of lifted term times minor
		always_ff @(posedge clk) begin
			ll_s6[g] <= s_lo * m_lo;
			lh_s6[g] <= $signed({1'b0, s_lo}) * m_hi;
			hl_s6[g] <= s_hi * m_lo;
			hh_s6[g] <= $signed({1'b0, s_hi}) * m_hi;
		end

		// outer products abut directly, cross products summed
		always_ff @(posedge clk) begin
			hi_s7[g]  <= {hh_s6[g], ll_s6[g]};
			mid_s7[g] <= {lh_s6[g][LHW-1], lh_s6[g]} + {3'b000, hl_s6[g]};
		end

		// fold the middle sum in at its weight
		always_ff @(posedge clk) begin
			term_s8[g] <= hi_s7[g] + ({{(TW-MDW){mid_s7[g][MDW-1]}}, mid_s7[g]} << L);
		end
	end

	// first two terms added, third carried along
	always_ff @(posedge clk) begin
		pair_s9 <= {term_s8[0][TW-1], term_s8[0]} + {term_s8[1][TW-1], term_s8[1]};
		last_s9 <= {term_s8[2][TW-1], term_s8[2]};
	end

	// full determinant and strict sign test
	assign det_c = pair_s9 + last_s9;

	always_ff @(posedge clk) begin
		inside_s10 <= !det_c[DW-1] && (det_c != '0);
	end

	assign res_ctl   = ctl_s10;
	assign in_circle = inside_s10;

endmodule

[design/triangle_incircle_test.sv]
// top level of the exact incircle test: orientation, vertex order, lifted terms, minors
// depends on tic_pkg, tic_det_sum and triangle_incircle_test_assert.svh
`include "triangle_incircle_test_assert.svh"

// Exact incircle predicate, fully pipelined. A transfer is taken on every
// clock edge with start high (busy is held low), so one item per cycle is
// sustained. The result appears on inside_res and reordered with done high
// for one cycle, once the transfer has passed the ten register stages of the
// datapath (orientation, vertex reorder, squares and cross products, lifted
// terms and minors, split wide products and a two-step final sum). The
// receiver cannot stall, and none is needed.
// Coordinates are COORD_BITS wide two's complement; arithmetic is exact.
module triangle_incircle_test import tic_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic signed [COORD_BITS-1:0] third_x,
	input  logic signed [COORD_BITS-1:0] third_y,
	input  logic signed [COORD_BITS-1:0] query_x,
	input  logic signed [COORD_BITS-1:0] query_y,
	output logic                         done,
	output logic                         inside_res,
	output logic                         reordered
);

	localparam int N   = COORD_BITS;
	localparam int CW  = N + 1;          // coordinate difference
	localparam int PW  = 2 * N + 2;      // product of two differences
	localparam int SQW = 2 * N;          // square of a difference
	localparam int XW  = 2 * N + 1;      // cross product of two differences
	localparam int SW  = 2 * N + 1;      // lifted term
	localparam int MW  = 2 * N + 2;      // 2x2 minor

	logic v_s1, v_s2, v_s3, v_s4;
	logic swap_s3, swap_s4;
	tic_ctl_t ctl_s5;
	tic_ctl_t tail_ctl;
	logic tail_inside;

	logic signed [CW-1:0] e1_s1, e2_s1, e3_s1, e4_s1;
	logic signed [N-1:0]  ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1, dx_s1, dy_s1;
	logic signed [PW-1:0] po1_s2, po2_s2;
	logic signed [N-1:0]  ax_s2, ay_s2, bx_s2, by_s2, cx_s2, cy_s2, dx_s2, dy_s2;

	logic                 swap_c;
	logic signed [N-1:0]  sa_x, sa_y, sb_x, sb_y;

	logic signed [CW-1:0] px_s3 [3];
	logic signed [CW-1:0] py_s3 [3];
	logic        [SQW-1:0] sqx_s4 [3];
	logic        [SQW-1:0] sqy_s4 [3];
	logic signed [XW-1:0] xy_s4 [3];
	logic signed [XW-1:0] yx_s4 [3];
	logic        [SW-1:0] s_s5 [3];
	logic signed [MW-1:0] m_s5 [3];

	// every cycle is open to a new transfer
	assign busy = 1'b0;

	// valid and swap flags through the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			swap_s3 <= 1'b0;
			swap_s4 <= 1'b0;
			ctl_s5  <= '0;
		end else begin
			v_s1         <= start && !busy;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			v_s4         <= v_s3;
			swap_s3      <= swap_c;
			swap_s4      <= swap_s3;
			ctl_s5.valid   <= v_s4;
			ctl_s5.swapped <= swap_s4;
		end
	end

	// stage 1: edge vectors for the orientation test
	always_ff @(posedge clk) begin
		e1_s1 <= {second_x[N-1], second_x} - {first_x[N-1], first_x};
		e2_s1 <= {third_y[N-1], third_y} - {second_y[N-1], second_y};
		e3_s1 <= {second_y[N-1], second_y} - {first_y[N-1], first_y};
		e4_s1 <= {third_x[N-1], third_x} - {second_x[N-1], second_x};
		ax_s1 <= first_x;
		ay_s1 <= first_y;
		bx_s1 <= second_x;
		by_s1 <= second_y;
		cx_s1 <= third_x;
		cy_s1 <= third_y;
		dx_s1 <= query_x;
		dy_s1 <= query_y;
	end

	// stage 2: the two orientation products
	always_ff @(posedge clk) begin
		po1_s2 <= e1_s1 * e2_s1;
		po2_s2 <= e3_s1 * e4_s1;
		ax_s2  <= ax_s1;
		ay_s2  <= ay_s1;
		bx_s2  <= bx_s1;
		by_s2  <= by_s1;
		cx_s2  <= cx_s1;
		cy_s2  <= cy_s1;
		dx_s2  <= dx_s1;
		dy_s2  <= dy_s1;
	end

	// clockwise triangles get their first two vertices exchanged
	always_comb begin
		swap_c = po1_s2 < po2_s2;
		sa_x   = swap_c ? bx_s2 : ax_s2;
		sa_y   = swap_c ? by_s2 : ay_s2;
		sb_x   = swap_c ? ax_s2 : bx_s2;
		sb_y   = swap_c ? ay_s2 : by_s2;
	end

	// stage 3: vertices relative to the query point
	always_ff @(posedge clk) begin
		px_s3[0] <= {sa_x[N-1], sa_x} - {dx_s2[N-1], dx_s2};
		py_s3[0] <= {sa_y[N-1], sa_y} - {dy_s2[N-1], dy_s2};
		px_s3[1] <= {sb_x[N-1], sb_x} - {dx_s2[N-1], dx_s2};
		py_s3[1] <= {sb_y[N-1], sb_y} - {dy_s2[N-1], dy_s2};
		px_s3[2] <= {cx_s2[N-1], cx_s2} - {dx_s2[N-1], dx_s2};
		py_s3[2] <= {cy_s2[N-1], cy_s2} - {dy_s2[N-1], dy_s2};
	end

	// one lane per row: lifted term and the cofactor minor of that row
	for (genvar g = 0; g < 3; g++) begin : g_row
		localparam int J = (g + 1) % 3;
		localparam int K = (g + 2) % 3;

		logic signed [PW-1:0] sqx_c, sqy_c, xy_c, yx_c;

		assign sqx_c = px_s3[g] * px_s3[g];
		assign sqy_c = py_s3[g] * py_s3[g];
		assign xy_c  = px_s3[J] * py_s3[K];
		assign yx_c  = py_s3[J] * px_s3[K];

		// stage 4: squares and cross products
		always_ff @(posedge clk) begin
			sqx_s4[g] <= sqx_c[SQW-1:0];
			sqy_s4[g] <= sqy_c[SQW-1:0];
			xy_s4[g]  <= xy_c[XW-1:0];
			yx_s4[g]  <= yx_c[XW-1:0];
		end

		// stage 5: lifted term and minor
		always_ff @(posedge clk) begin
			s_s5[g] <= {1'b0, sqx_s4[g]} + {1'b0, sqy_s4[g]};
			m_s5[g] <= {xy_s4[g][XW-1], xy_s4[g]} - {yx_s4[g][XW-1], yx_s4[g]};
		end
	end

	// wide products and determinant sign
	tic_det_sum #(
		.COORD_BITS(COORD_BITS)
	) u_det_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_s5),
		.sq        (s_s5),
		.mn        (m_s5),
		.res_ctl   (tail_ctl),
		.in_circle (tail_inside)
	);

	assign done       = tail_ctl.valid;
	assign reordered  = tail_ctl.swapped;
	assign inside_res = tail_inside;

	// every transfer gives its result a fixed time later, and nothing else does
	`TIC_ASSERT_DLY(a_result_follows_transfer, start && !busy, TIC_LATENCY, done, "no result")
	`TIC_ASSERT_IMP(a_no_stray_result, done, $past(start && !busy, TIC_LATENCY), "stray result")

endmodule
